@@ sv/trf_pkg.sv @@
// ----------------------------------------------------------------------------
// trf_pkg
// Shared types and constants for the two-pole resonator filter.
// ----------------------------------------------------------------------------
`default_nettype none

package trf_pkg;

  localparam int OUT_WIDTH = 24;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_FREQ = 2'd0;
  localparam logic [1:0] REG_BW   = 2'd1;
  localparam logic [1:0] REG_SR   = 2'd2;

  localparam logic [16:0] FREQ_RESET = 17'd4000;
  localparam logic [16:0] BW_RESET   = 17'd1000;
  localparam logic [17:0] SR_RESET   = 18'd48000;

  // 2*pi/ln2 in Q24, ln2 in Q32, pi/2 in Q32 less 2^32
  localparam logic [31:0] EXP_K_Q24 = 32'd152080770;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [31:0] HALFPI_LO = 32'd2451551556;

  localparam logic [31:0] ONE_Q30  = 32'h4000_0000;
  localparam logic [63:0] C2_MAX   = 64'h0000_0000_7FFF_FFFF;
  localparam logic [3:0]  TAY_LAST = 4'd11;

  localparam logic signed [63:0] OUT_HI = 64'sd8388607;
  localparam logic signed [63:0] OUT_LO = -64'sd8388608;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_CHK, OP_DIV_R, OP_T_LO, OP_T_HI, OP_U,
    OP_EXP_INIT, OP_TAY_MUL, OP_TAY_DIV, OP_TAY_UPD, OP_C3,
    OP_DIV_PH, OP_PH, OP_THETA, OP_X2, OP_COS_INIT, OP_SAVE_CB,
    OP_SIN_INIT, OP_COSQ, OP_NUM, OP_DIV_C2, OP_C2,
    OP_F1_LO, OP_F1_HI, OP_F2_LO, OP_F2_HI, OP_F_UPD
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic cvalid;
    logic div_busy;
    logic tay_last;
    logic out_free;
  } stat_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_DIV_R, S_W_R, S_T_LO, S_T_HI, S_U, S_EXP_INIT,
    S_TMUL, S_TDIV, S_TW, S_TUPD, S_C3, S_DIV_PH, S_W_PH, S_PH,
    S_THETA, S_X2, S_COS_INIT, S_SAVE_CB, S_SIN_INIT, S_COSQ, S_NUM,
    S_DIV_C2, S_W_C2, S_C2, S_F1_LO, S_F1_HI, S_F2_LO, S_F2_HI, S_F_UPD
  } state_t;

  typedef enum logic [1:0] {
    K_EXP, K_COS, K_SIN
  } kind_t;

endpackage

`default_nettype wire

@@ sv/trf_div.sv @@
// ----------------------------------------------------------------------------
// trf_div
// Restoring divider, one quotient bit per cycle, 64-bit by 32-bit.
// ----------------------------------------------------------------------------
`default_nettype none

module trf_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic [63:0]      quo
);

  logic [31:0] rem;
  logic [6:0]  cnt;
  logic [31:0] dsr;
  logic [32:0] trial;
  logic        fits;

  always_comb begin
    trial = {rem, quo[63]};
    fits  = trial >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 7'd0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 7'd64;
    end else if (busy) begin
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= 32'd0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? 32'(trial - {1'b0, dsr}) : trial[31:0];
      quo <= {quo[62:0], fits};
    end
  end

endmodule

`default_nettype wire

@@ sv/trf_datapath.sv @@
// ----------------------------------------------------------------------------
// trf_datapath
// Config registers, coefficient arithmetic, filter state and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module trf_datapath
  import trf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int STATE_WIDTH  = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire cmd_t                    cmd,
  output stat_t                        stat,
  input  wire logic [SAMPLE_WIDTH-1:0] sample_in,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [OUT_WIDTH-1:0]         sample_out,
  input  wire logic                    cfg_we,
  input  wire logic [1:0]              cfg_idx,
  input  wire logic [31:0]             cfg_wdata,
  output logic [31:0]                  cfg_rdata
);

  localparam logic signed [63:0] ST_HI = (64'sd1 <<< (STATE_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] ST_LO = -ST_HI - 64'sd1;

  logic [16:0] cfg_freq;
  logic [16:0] cfg_bw;
  logic [17:0] cfg_sr;
  logic        cvalid;

  logic signed [SAMPLE_WIDTH-1:0] x_in;
  logic signed [STATE_WIDTH-1:0]  y1, y2;
  logic signed [63:0]             acc;

  logic [17:0] sr_eff;
  logic        wide;
  logic [63:0] wk;
  logic [37:0] t;
  logic [31:0] xv;
  logic [32:0] term, sum, pq, cb;
  logic [4:0]  k;
  logic        step2, sub;
  logic [3:0]  i;
  logic [9:0]  dv;
  logic [30:0] c3, cosq;
  logic [1:0]  quad;
  logic        folded, neg_c;
  logic [29:0] bq;
  logic [31:0] theta;
  logic signed [31:0] c2;

  logic        div_start, div_busy;
  logic [63:0] div_dividend, quo;
  logic [31:0] div_divisor;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  logic [17:0] srv;
  logic [4:0]  k1, k2;
  logic [9:0]  dv_prod;
  logic [31:0] c2m;
  logic signed [63:0] y1s, y2s, y0, ot;
  logic [63:0] y1m, y2m, fm, hi_sum;
  logic [30:0] e31;
  logic [30:0] fold_diff;
  logic [32:0] cq, sq, mag;
  logic        neg1, neg2;

  trf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quo      (quo)
  );

  always_comb begin
    srv       = (cfg_sr == 18'd0) ? 18'd1 : cfg_sr;
    k1        = k + 5'd1;
    k2        = k + 5'd2;
    dv_prod   = k1 * k2;
    c2m       = c2[31] ? (~c2 + 32'd1) : c2;
    y1s       = {{(64 - STATE_WIDTH){y1[STATE_WIDTH-1]}}, y1};
    y2s       = {{(64 - STATE_WIDTH){y2[STATE_WIDTH-1]}}, y2};
    y1m       = y1[STATE_WIDTH-1] ? (~y1s + 64'd1) : y1s;
    y2m       = y2[STATE_WIDTH-1] ? (~y2s + 64'd1) : y2s;
    neg1      = c2[31] ^ y1[STATE_WIDTH-1];
    neg2      = y2[STATE_WIDTH-1];
    e31       = sum[32:2];
    fold_diff = {1'b1, 30'd0} - {1'b0, quo[29:0]};
    cq        = folded ? sum : cb;
    sq        = folded ? cb : sum;
    mag       = quad[0] ? sq : cq;
    y0        = (acc > ST_HI) ? ST_HI : ((acc < ST_LO) ? ST_LO : acc);
    ot        = (y0 > OUT_HI) ? OUT_HI : ((y0 < OUT_LO) ? OUT_LO : y0);
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (cmd.op)
      OP_T_LO:    begin mul_a = quo[31:0];            mul_b = EXP_K_Q24; end
      OP_T_HI:    begin mul_a = {30'd0, quo[33:32]};  mul_b = EXP_K_Q24; end
      OP_U:       begin mul_a = t[31:0];              mul_b = LN2_Q32;   end
      OP_TAY_MUL: begin mul_a = xv;                   mul_b = term[31:0]; end
      OP_THETA:   begin mul_a = {2'd0, bq};           mul_b = HALFPI_LO; end
      OP_X2:      begin mul_a = theta;                mul_b = theta;     end
      OP_NUM:     begin mul_a = {1'b0, c3};           mul_b = {1'b0, cosq}; end
      OP_F1_LO:   begin mul_a = c2m;                  mul_b = y1m[31:0]; end
      OP_F1_HI:   begin mul_a = c2m;                  mul_b = y1m[63:32]; end
      OP_F2_LO:   begin mul_a = {1'b0, c3};           mul_b = y2m[31:0]; end
      OP_F2_HI:   begin mul_a = {1'b0, c3};           mul_b = y2m[63:32]; end
      default:    begin mul_a = 32'd0;                mul_b = 32'd0;     end
    endcase
    prod   = mul_a * mul_b;
    hi_sum = wk + {prod[31:0], 32'd0};
    fm     = wk + {prod[61:0], 2'd0};
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = 64'd0;
    div_divisor  = 32'd1;
    case (cmd.op)
      OP_DIV_R: begin
        div_start    = 1'b1;
        div_dividend = {15'd0, cfg_bw, 32'd0};
        div_divisor  = {14'd0, sr_eff};
      end
      OP_TAY_DIV: begin
        div_start    = 1'b1;
        div_dividend = {31'd0, pq};
        div_divisor  = {22'd0, dv};
      end
      OP_DIV_PH: begin
        div_start    = 1'b1;
        div_dividend = {15'd0, cfg_freq, 32'd0};
        div_divisor  = {14'd0, sr_eff};
      end
      OP_DIV_C2: begin
        div_start    = 1'b1;
        div_dividend = {wk[61:0], 2'd0};
        div_divisor  = ONE_Q30 + {1'b0, c3};
      end
      default: begin
        div_start    = 1'b0;
      end
    endcase
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_freq <= FREQ_RESET;
      cfg_bw   <= BW_RESET;
      cfg_sr   <= SR_RESET;
      cvalid   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_FREQ: begin cfg_freq <= cfg_wdata[16:0]; cvalid <= 1'b0; end
        REG_BW:   begin cfg_bw   <= cfg_wdata[16:0]; cvalid <= 1'b0; end
        REG_SR:   begin cfg_sr   <= cfg_wdata[17:0]; cvalid <= 1'b0; end
        default:  begin end
      endcase
    end else if (cmd.op == OP_C2) begin
      cvalid <= 1'b1;
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FREQ: cfg_rdata = {15'd0, cfg_freq};
      REG_BW:   cfg_rdata = {15'd0, cfg_bw};
      REG_SR:   cfg_rdata = {14'd0, cfg_sr};
      default:  cfg_rdata = 32'd0;
    endcase
  end

  // filter state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      y1        <= '0;
      y2        <= '0;
      out_valid <= 1'b0;
    end else if (cmd.op == OP_F_UPD) begin
      y1        <= y0[STATE_WIDTH-1:0];
      y2        <= y1;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD:     x_in <= sample_in;
      OP_CHK: begin
        sr_eff <= srv;
        wide   <= {3'd0, cfg_bw} >= {srv, 2'd0};
      end
      OP_T_LO:     wk <= prod;
      OP_T_HI:     t  <= hi_sum[61:24];
      OP_U:        xv <= prod[63:32];
      OP_EXP_INIT, OP_COS_INIT: begin
        term  <= {1'b1, 32'd0};
        sum   <= {1'b1, 32'd0};
        k     <= 5'd0;
        step2 <= (cmd.op == OP_COS_INIT);
        sub   <= 1'b1;
        i     <= 4'd0;
      end
      OP_SIN_INIT: begin
        term  <= {1'b0, theta};
        sum   <= {1'b0, theta};
        k     <= 5'd1;
        step2 <= 1'b1;
        sub   <= 1'b1;
        i     <= 4'd0;
      end
      OP_TAY_MUL: begin
        pq <= term[32] ? {1'b0, xv} : {1'b0, prod[63:32]};
        dv <= step2 ? dv_prod : {5'd0, k1};
      end
      OP_TAY_UPD: begin
        term <= quo[32:0];
        sum  <= sub ? (sum - quo[32:0]) : (sum + quo[32:0]);
        k    <= step2 ? k2 : k1;
        sub  <= ~sub;
        i    <= i + 4'd1;
      end
      OP_C3:       c3 <= wide ? 31'd0 : (e31 >> t[37:32]);
      OP_PH: begin
        quad   <= quo[31:30];
        folded <= quo[29];
        bq     <= quo[29] ? fold_diff[29:0] : quo[29:0];
      end
      OP_THETA:    theta <= 32'((prod + {bq, 32'd0}) >> 30);
      OP_X2:       xv <= prod[63:32];
      OP_SAVE_CB:  cb <= sum;
      OP_COSQ: begin
        neg_c <= quad[1] ^ quad[0];
        cosq  <= mag[32:2];
      end
      OP_NUM:      wk <= prod;
      OP_C2: begin
        if (neg_c) begin
          c2 <= ~quo[31:0] + 32'd1;
        end else begin
          c2 <= (quo > C2_MAX) ? C2_MAX[31:0] : quo[31:0];
        end
      end
      OP_F1_LO: begin
        acc <= {{(64 - SAMPLE_WIDTH){x_in[SAMPLE_WIDTH-1]}}, x_in};
        wk  <= prod >> 30;
      end
      OP_F1_HI:    acc <= neg1 ? (acc - $signed(fm)) : (acc + $signed(fm));
      OP_F2_LO:    wk  <= prod >> 30;
      OP_F2_HI:    acc <= neg2 ? (acc + $signed(fm)) : (acc - $signed(fm));
      OP_F_UPD:    sample_out <= ot[OUT_WIDTH-1:0];
      default: begin end
    endcase
  end

  always_comb begin
    stat.cvalid   = cvalid;
    stat.div_busy = div_busy;
    stat.tay_last = (i == TAY_LAST);
    stat.out_free = ~out_valid | out_ready;
  end

endmodule

`default_nettype wire

@@ sv/trf_ctrl.sv @@
// ----------------------------------------------------------------------------
// trf_ctrl
// Sequencer: coefficient recompute and the per-sample multiply-accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

module trf_ctrl
  import trf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state, state_next;
  kind_t  kind, kind_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= K_EXP;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

  always_comb begin
    state_next = state;
    kind_next  = kind;
    unique case (state)
      S_IDLE:     if (in_valid) begin
                    state_next = stat.cvalid ? S_F1_LO : S_CHK;
                  end
      S_CHK:      state_next = S_DIV_R;
      S_DIV_R:    state_next = S_W_R;
      S_W_R:      if (!stat.div_busy) state_next = S_T_LO;
      S_T_LO:     state_next = S_T_HI;
      S_T_HI:     state_next = S_U;
      S_U:        state_next = S_EXP_INIT;
      S_EXP_INIT: begin state_next = S_TMUL; kind_next = K_EXP; end
      S_TMUL:     state_next = S_TDIV;
      S_TDIV:     state_next = S_TW;
      S_TW:       if (!stat.div_busy) state_next = S_TUPD;
      S_TUPD: begin
        if (!stat.tay_last) begin
          state_next = S_TMUL;
        end else begin
          unique case (kind)
            K_EXP:   state_next = S_C3;
            K_COS:   state_next = S_SAVE_CB;
            default: state_next = S_COSQ;
          endcase
        end
      end
      S_C3:       state_next = S_DIV_PH;
      S_DIV_PH:   state_next = S_W_PH;
      S_W_PH:     if (!stat.div_busy) state_next = S_PH;
      S_PH:       state_next = S_THETA;
      S_THETA:    state_next = S_X2;
      S_X2:       state_next = S_COS_INIT;
      S_COS_INIT: begin state_next = S_TMUL; kind_next = K_COS; end
      S_SAVE_CB:  state_next = S_SIN_INIT;
      S_SIN_INIT: begin state_next = S_TMUL; kind_next = K_SIN; end
      S_COSQ:     state_next = S_NUM;
      S_NUM:      state_next = S_DIV_C2;
      S_DIV_C2:   state_next = S_W_C2;
      S_W_C2:     if (!stat.div_busy) state_next = S_C2;
      S_C2:       state_next = S_F1_LO;
      S_F1_LO:    state_next = S_F1_HI;
      S_F1_HI:    state_next = S_F2_LO;
      S_F2_LO:    state_next = S_F2_HI;
      S_F2_HI:    state_next = S_F_UPD;
      S_F_UPD:    if (stat.out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op   = OP_NONE;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.op   = in_valid ? OP_LOAD : OP_NONE;
      end
      S_CHK:      cmd.op = OP_CHK;
      S_DIV_R:    cmd.op = OP_DIV_R;
      S_T_LO:     cmd.op = OP_T_LO;
      S_T_HI:     cmd.op = OP_T_HI;
      S_U:        cmd.op = OP_U;
      S_EXP_INIT: cmd.op = OP_EXP_INIT;
      S_TMUL:     cmd.op = OP_TAY_MUL;
      S_TDIV:     cmd.op = OP_TAY_DIV;
      S_TUPD:     cmd.op = OP_TAY_UPD;
      S_C3:       cmd.op = OP_C3;
      S_DIV_PH:   cmd.op = OP_DIV_PH;
      S_PH:       cmd.op = OP_PH;
      S_THETA:    cmd.op = OP_THETA;
      S_X2:       cmd.op = OP_X2;
      S_COS_INIT: cmd.op = OP_COS_INIT;
      S_SAVE_CB:  cmd.op = OP_SAVE_CB;
      S_SIN_INIT: cmd.op = OP_SIN_INIT;
      S_COSQ:     cmd.op = OP_COSQ;
      S_NUM:      cmd.op = OP_NUM;
      S_DIV_C2:   cmd.op = OP_DIV_C2;
      S_C2:       cmd.op = OP_C2;
      S_F1_LO:    cmd.op = OP_F1_LO;
      S_F1_HI:    cmd.op = OP_F1_HI;
      S_F2_LO:    cmd.op = OP_F2_LO;
      S_F2_HI:    cmd.op = OP_F2_HI;
      S_F_UPD:    cmd.op = stat.out_free ? OP_F_UPD : OP_NONE;
      default:    cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/two_pole_resonator_filter.sv @@
// ----------------------------------------------------------------------------
// two_pole_resonator_filter
// Two-pole resonator, y = x + c2*y1 - c3*y2, coefficients from APB registers.
//
// Input stream s_*: one signed sample per beat. Output stream m_*: one
// 24-bit saturated sample per input beat, in order.
// APB registers: 0x0 center frequency, 0x4 bandwidth, 0x8 sample rate (Hz).
// A sample is taken in the idle state; after any coefficient recompute it
// steps through F1_LO, F1_HI, F2_LO and F2_HI; F_UPD registers the result
// before the next sample is taken. The four steps are set by the shared 32x32
// multiplier, used twice per feedback product. The first sample after reset
// or after a defined register write first runs the coefficient recompute:
// three divides plus 36 Taylor terms, each with a divide, on the one divider.
// Reset restores the register defaults and clears the filter history.
// When the receiver stalls, the result waits in the output register; the
// next sample is still taken and held until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module two_pole_resonator_filter
  import trf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int STATE_WIDTH  = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_tdata,   // sample_in
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [OUT_WIDTH-1:0]                     m_tdata,   // sample_out
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [3:0]                          paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);

  cmd_t  cmd;
  stat_t stat;
  logic  cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  trf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  trf_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .STATE_WIDTH  (STATE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .sample_in  (s_tdata[SAMPLE_WIDTH-1:0]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .sample_out (m_tdata),
    .cfg_we     (cfg_we),
    .cfg_idx    (paddr[3:2]),
    .cfg_wdata  (pwdata),
    .cfg_rdata  (prdata)
  );

endmodule

`default_nettype wire

@@ tb/resonator_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resonator_checker
// Watches the register port and both sample streams, keeps its own copy of
// the coefficients and filter history, and compares every output beat
// against the oldest predicted sample.
// ----------------------------------------------------------------------------
module resonator_checker
  import trf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // sample_in
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,   // sample_out
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);

  typedef longint unsigned u64;

  localparam u64 M32        = 64'hFFFF_FFFF;
  localparam u64 ONE32      = 64'h1_0000_0000;
  localparam u64 Q30        = 64'h4000_0000;
  localparam u64 HALFPI_Q32 = 64'd6746518852;

  logic [16:0] freq_hz;
  logic [16:0] bw_hz;
  logic [17:0] sr_hz;
  longint      y1, y2, gain_one, gain_two;
  bit          gains_ok;
  logic [23:0] filtered_q[$];

  function automatic u64 taylor_sum(input u64 x, input u64 term, input int unsigned k,
                                    input int unsigned step);
    u64 sum;
    u64 div;
    bit sub;
    sum = term;
    sub = 1;
    for (int i = 0; i < 12; i++) begin
      div = k + 1;
      if (step == 2) div = div * (k + 2);
      term = ((term * x) >> 32) / div;
      k += step;
      sum = sub ? sum - term : sum + term;
      sub = !sub;
    end
    return sum;
  endfunction

  function automatic longint mul_q30(input longint c, input longint y);
    bit neg;
    u64 cm, ym, r;
    neg = (c < 0) != (y < 0);
    cm = (c < 0) ? u64'(-c) : u64'(c);
    ym = (y < 0) ? u64'(-y) : u64'(y);
    r = ((cm * (ym >> 32)) << 2) + ((cm * (ym & M32)) >> 30);
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clamp(input longint v, input int w);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  task automatic update_gains();
    u64 sr, bw, c3, r, t, u, e, ph, a, b, theta, x2, cb, sb, cq, sq, mag, cosq, c2mag;
    int unsigned n, q;
    bit folded, neg;
    sr = (sr_hz == 0) ? 1 : u64'(sr_hz);
    bw = u64'(bw_hz);
    if (bw >= 4 * sr) begin
      c3 = 0;
    end else begin
      r = (bw << 32) / sr;
      t = (r * u64'(EXP_K_Q24)) >> 24;
      n = int'(t >> 32);
      u = ((t & M32) * u64'(LN2_Q32)) >> 32;
      e = taylor_sum(u, ONE32, 0, 1);
      c3 = (e >> 2) >> n;
    end
    ph = ((u64'(freq_hz) << 32) / sr) & M32;
    q = int'(ph >> 30);
    a = ph & (Q30 - 1);
    folded = a >= (Q30 >> 1);
    b = folded ? Q30 - a : a;
    theta = (b * HALFPI_Q32) >> 30;
    x2 = (theta * theta) >> 32;
    cb = taylor_sum(x2, ONE32, 0, 2);
    sb = taylor_sum(x2, theta, 1, 2);
    cq = folded ? sb : cb;
    sq = folded ? cb : sb;
    mag = q[0] ? sq : cq;
    neg = (q == 1) || (q == 2);
    cosq = mag >> 2;
    c2mag = ((c3 * cosq) * 4) / (Q30 + c3);
    if (neg) gain_one = -longint'(c2mag);
    else gain_one = (c2mag > u64'(C2_MAX)) ? longint'(C2_MAX) : longint'(c2mag);
    gain_two = longint'(c3);
    gains_ok = 1;
  endtask

  task automatic filter_sample(input logic [15:0] raw);
    longint acc, y0;
    if (!gains_ok) update_gains();
    acc = longint'($signed(raw)) + mul_q30(gain_one, y1) - mul_q30(gain_two, y2);
    y0 = clamp(acc, 32);
    y2 = y1;
    y1 = y0;
    filtered_q.push_back(24'(clamp(y0, OUT_WIDTH)));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      freq_hz  <= FREQ_RESET;
      bw_hz    <= BW_RESET;
      sr_hz    <= SR_RESET;
      y1 = 0;
      y2 = 0;
      gain_one = 0;
      gain_two = 0;
      gains_ok = 0;
      filtered_q.delete();
      errors <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_FREQ: begin freq_hz <= pwdata[16:0]; gains_ok = 0; end
          REG_BW:   begin bw_hz   <= pwdata[16:0]; gains_ok = 0; end
          REG_SR:   begin sr_hz   <= pwdata[17:0]; gains_ok = 0; end
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (filtered_q.size() == 0) begin
          $display("%0t: unexpected output beat, expected none, actual %h", $time, m_tdata);
          errors <= errors + 1;
        end else if (filtered_q[0] !== m_tdata) begin
          $display("%0t: sample_out mismatch, expected %h, actual %h",
                   $time, filtered_q[0], m_tdata);
          errors <= errors + 1;
          void'(filtered_q.pop_front());
        end else begin
          void'(filtered_q.pop_front());
        end
      end
      if (s_tvalid && s_tready) filter_sample(s_tdata);
    end
    pending <= filtered_q.size();
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the resonator through a series of register settings, feeding bursty
// sample streams against a stalling receiver; the checker predicts each output.
// ----------------------------------------------------------------------------
module tb
  import trf_pkg::*;
();

  localparam logic [1:0] REG_NONE = 2'd3;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // sample_in
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // sample_out
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          pending;
  int          stall_mode;
  int          burst_left;

  two_pole_resonator_filter dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  resonator_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  // receiver: stall behavior changes every so often
  initial begin
    m_tready = 0;
    stall_mode = 0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: m_tready <= 1;
        1: m_tready <= 1'($urandom_range(0, 1));
        default: m_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
    @(posedge clk);
  endtask

  task automatic send_sample(input logic [15:0] val);
    if (burst_left == 0) begin
      if (s_tvalid) begin
        s_tvalid <= 0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    s_tvalid <= 1;
    s_tdata  <= val;
    do @(posedge clk); while (!s_tready);
    burst_left--;
  endtask

  task automatic drain();
    if (s_tvalid) s_tvalid <= 0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_sample(input int style);
    case (style)
      0: return 16'h7FFF;
      1: return $urandom_range(0, 3) == 0 ? 16'h8000 : 16'h7FFF;
      default: begin
        case ($urandom_range(0, 7))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          default: return 16'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic run_phase(input int count);
    int style;
    style = $urandom_range(0, 5);
    for (int i = 0; i < count; i++) send_sample(pick_sample(style));
    drain();
  endtask

  logic [15:0] directed[] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001,
                              16'h5555, 16'hAAAA, 16'h7FFF, 16'h7FFF, 16'h8000,
                              16'h8000, 16'h0000, 16'h0000, 16'h00FF, 16'hFF00};

  initial begin
    rst = 1;
    s_tvalid = 0;
    s_tdata = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    burst_left = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (directed[i]) send_sample(directed[i]);
    drain();

    // largest c2: zero frequency and zero bandwidth, full-scale input makes the state grow
    reg_write(REG_FREQ, 32'd0);
    reg_write(REG_BW, 32'd0);
    for (int i = 0; i < 10; i++) send_sample(16'h7FFF);
    drain();

    // unknown register leaves coefficients alone
    reg_write(REG_NONE, 32'hFFFF_FFFF);
    run_phase(40);

    // very wide bandwidth
    reg_write(REG_BW, 32'd96000);
    reg_write(REG_SR, 32'd8000);
    reg_write(REG_FREQ, 32'd96000);
    run_phase(40);

    // zero sample rate
    reg_write(REG_SR, 32'd0);
    reg_write(REG_BW, 32'd0);
    reg_write(REG_FREQ, 32'd1);
    run_phase(40);

    // all register bits set, upper bits dropped
    reg_write(REG_FREQ, 32'hFFFF_FFFF);
    reg_write(REG_BW, 32'hFFFF_FFFF);
    reg_write(REG_SR, 32'hFFFF_FFFF);
    run_phase(40);

    reg_write(REG_SR, 32'd192000);
    reg_write(REG_FREQ, 32'd24000);
    reg_write(REG_BW, 32'd10);
    run_phase(40);

    reg_write(REG_SR, 32'd48000);
    reg_write(REG_FREQ, 32'd24000);
    reg_write(REG_BW, 32'd1);
    run_phase(40);

    for (int p = 0; p < 10; p++) begin
      if ($urandom_range(0, 1)) reg_write(REG_FREQ, $urandom_range(0, 96000));
      if ($urandom_range(0, 1)) reg_write(REG_BW, $urandom_range(0, 3) == 0 ?
                                          $urandom_range(0, 96000) : $urandom_range(0, 500));
      if ($urandom_range(0, 1)) reg_write(REG_SR, $urandom_range(8000, 192000));
      run_phase($urandom_range(40, 65));
    end

    repeat (50) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
